FILE: hdl/altitude_pi_thrust_controller_defines.svh
// Assertion macros for the altitude thrust controller.
// No dependencies.
`ifndef ALTITUDE_PI_THRUST_CONTROLLER_DEFINES_SVH
`define ALTITUDE_PI_THRUST_CONTROLLER_DEFINES_SVH
// implication checked at every clock edge outside reset
`define APTC_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication
`define APTC_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

FILE: hdl/aptc_pkg.sv
// Shared constants and types for the altitude thrust controller.
// No dependencies.
package aptc_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CFG_W = 31;
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] REG_GAIN_POS = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_INT = 3'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_VEL = 3'd2;
   localparam logic [IDX_W-1:0] REG_MAX_ASC  = 3'd3;
   localparam logic [IDX_W-1:0] REG_MAX_DESC = 3'd4;
   localparam logic [IDX_W-1:0] REG_MASS     = 3'd5;
   localparam logic [IDX_W-1:0] REG_STEP     = 3'd6;
   // serial unit operation
   typedef enum logic [1:0] {OP_MUL = 2'd0, OP_DIV = 2'd1} op_type;
   typedef struct packed {
      logic   start;
      op_type op;
   } su_ctl_type;
endpackage

FILE: hdl/altitude_pi_thrust_controller.sv
// Top level of the altitude PI-D thrust controller with tilt compensation.
// Depends on aptc_pkg, aptc_serial_unit and the defines header.
//
// One control step per request. All products and divisions run through one
// shared bit-serial unit. A step issues twelve operations: the integral
// product and its step-time scaling, the proportional and velocity products,
// two rate-limit divisions, four quaternion squares, the thrust product and
// the thrust division; a tilt fault skips the thrust division. A finished
// step moves into an output register that holds the answer until taken; the
// next request is accepted once the step has moved there, so an untaken
// result stalls the input only when the following step is finished as well.
// Configuration is written through csr_ by the user only at idle time, which
// the block itself leaves unenforced. The quaternion tilt term is formed by
// the same unit.
`include "altitude_pi_thrust_controller_defines.svh"
module altitude_pi_thrust_controller #(
   parameter int FRAC_BITS = aptc_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [aptc_pkg::IDX_W-1:0] csr_index,
   input  logic [aptc_pkg::CFG_W-1:0] csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // target_alt, target_vz, measured_alt, measured_vz, feedfwd_az,
   // quat_w, quat_x, quat_y, quat_z
   input  logic [223:0]               req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // thrust_out
   output logic [31:0]                rsp_tdata,
   // tilt_fault
   output logic                       rsp_tuser
);
   import aptc_pkg::*;
   localparam int W = 64;
   localparam logic signed [W-1:0] I32MAX = 64'sd2147483647;
   localparam logic signed [W-1:0] I32MIN = -64'sd2147483648;
   localparam logic signed [W-1:0] TLIM = 64'sd35184372088831;
   localparam logic signed [W-1:0] NLIM = 64'sd17179869184;
   localparam logic signed [W-1:0] GCONST =
      W'((981 * (64'sd1 <<< FRAC_BITS) + 50) / 100);

   typedef enum logic [11:0] {
      S_IDLE = 12'h001, S_P = 12'h002, S_D = 12'h004, S_A = 12'h008,
      S_B = 12'h010, S_HI = 12'h020, S_LO = 12'h040, S_QW = 12'h080,
      S_QX = 12'h100, S_NUM = 12'h200, S_DIVT = 12'h400, S_OUT = 12'h800
   } state_type;

   // configuration
   logic [30:0] kp_ff, ki_ff, kv_ff, asc_ff, desc_ff, mass_ff;
   logic [16:0] dt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ki_ff <= '0; kv_ff <= '0; asc_ff <= 31'd6553600;
         desc_ff <= 31'd6553600; mass_ff <= 31'd65536; dt_ff <= 17'd655;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GAIN_POS: kp_ff <= csr_wdata;
            REG_GAIN_INT: ki_ff <= csr_wdata;
            REG_GAIN_VEL: kv_ff <= csr_wdata;
            REG_MAX_ASC:  asc_ff <= csr_wdata;
            REG_MAX_DESC: desc_ff <= csr_wdata;
            REG_MASS:     mass_ff <= csr_wdata;
            REG_STEP:     dt_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   state_type st_ff, st_in;
   logic signed [W-1:0] perr_ff, verr_ff, ff_ff, r22_ff, acc_ff, cmd_ff;
   logic signed [W-1:0] hi_ff, lo_ff, num_ff;
   logic signed [W-1:0] perr_in, verr_in, ff_in, r22_in, acc_in, cmd_in;
   logic signed [W-1:0] hi_in, lo_in, num_in;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff, qw_in, qx_in, qy_in, qz_in;
   logic signed [31:0] integ_ff, integ_in;
   logic [31:0] thr_ff, thr_in, out_thr_ff, out_thr_in;
   logic flt_ff, flt_in, out_flt_ff, out_flt_in;
   logic vld_ff, vld_in, neg_ff, neg_in;
   logic [1:0] sub_ff, sub_in;

   su_ctl_type ctl;
   logic [W-1:0] opa, opb, sres;
   logic sdone;
   aptc_serial_unit #(.W(W)) u_su (
      .clock(clock), .reset(reset), .ctl(ctl), .opa(opa), .opb(opb),
      .done(sdone), .res(sres)
   );

   logic signed [W-1:0] prod, fsh, pa, pb, sum;
   logic signed [W-1:0] dtd;
   logic acc_req;

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
      input logic signed [63:0] lo, input logic signed [63:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction
   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   assign acc_req = req_tvalid && req_tready;
   assign req_tready = (st_ff == S_IDLE);
   assign dtd = (dt_ff == 17'd0) ? 64'sd1 : W'(signed'({1'b0, dt_ff}));

   // start a signed multiply or divide on magnitudes; sign kept in neg
   task automatic issue(input op_type o, input logic signed [63:0] a,
      input logic signed [63:0] b);
      ctl.start = 1'b1; ctl.op = o; opa = mag(a); opb = mag(b);
      neg_in = a[63] ^ b[63];
   endtask

   always_comb begin
      st_in = st_ff; perr_in = perr_ff; verr_in = verr_ff; ff_in = ff_ff;
      r22_in = r22_ff; acc_in = acc_ff; cmd_in = cmd_ff; hi_in = hi_ff;
      lo_in = lo_ff; num_in = num_ff; qw_in = qw_ff; qx_in = qx_ff;
      qy_in = qy_ff; qz_in = qz_ff; integ_in = integ_ff; thr_in = thr_ff;
      flt_in = flt_ff; vld_in = vld_ff; neg_in = neg_ff; sub_in = sub_ff;
      out_thr_in = out_thr_ff; out_flt_in = out_flt_ff;
      ctl.start = 1'b0; ctl.op = OP_MUL; opa = '0; opb = '0;
      prod = neg_ff ? W'(-signed'(sres)) : signed'(sres);
      fsh = prod >>> FRAC_BITS;
      pa = '0; pb = '0; sum = '0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (acc_req) begin
            perr_in = W'(signed'(req_tdata[31:0])) - W'(signed'(req_tdata[95:64]));
            verr_in = W'(signed'(req_tdata[63:32])) - W'(signed'(req_tdata[127:96]));
            ff_in = W'(signed'(req_tdata[159:128]));
            qw_in = req_tdata[175:160]; qx_in = req_tdata[191:176];
            qy_in = req_tdata[207:192]; qz_in = req_tdata[223:208];
            issue(OP_MUL, W'(signed'(req_tdata[31:0])) - W'(signed'(req_tdata[95:64])),
               W'(signed'({1'b0, ki_ff})));
            st_in = S_A;
         end
         // integrator step scales by the raw step time, zero included
         S_A: if (sdone) begin
            issue(OP_MUL, clamp(fsh, -TLIM, TLIM), W'(signed'({1'b0, dt_ff})));
            st_in = S_B;
         end
         S_B: if (sdone) begin
            integ_in = 32'(clamp(W'(signed'(integ_ff)) + fsh, I32MIN, I32MAX));
            acc_in = W'(signed'(32'(clamp(W'(signed'(integ_ff)) + fsh, I32MIN,
               I32MAX)))) + ff_ff;
            issue(OP_MUL, perr_ff, W'(signed'({1'b0, kp_ff})));
            st_in = S_P;
         end
         S_P: if (sdone) begin
            acc_in = acc_ff + clamp(fsh, I32MIN, I32MAX);
            issue(OP_MUL, verr_ff, W'(signed'({1'b0, kv_ff})));
            st_in = S_D;
         end
         S_D: if (sdone) begin
            acc_in = acc_ff + clamp(fsh, I32MIN, I32MAX);
            issue(OP_DIV, W'(signed'({1'b0, asc_ff})) <<< FRAC_BITS, dtd);
            st_in = S_HI;
         end
         S_HI: if (sdone) begin
            hi_in = clamp(signed'(sres), 64'sd0, I32MAX);
            issue(OP_DIV, W'(signed'({1'b0, desc_ff})) <<< FRAC_BITS, dtd);
            st_in = S_LO;
         end
         S_LO: if (sdone) begin
            lo_in = -clamp(signed'(sres), 64'sd0, -I32MIN);
            issue(OP_MUL, W'(qw_ff), W'(qw_ff));
            sub_in = 2'd0;
            st_in = S_QW;
         end
         // four squares, combined into r22 as w^2 - x^2 - y^2 + z^2
         S_QW: if (sdone) begin
            sum = (sub_ff == 2'd0) ? prod :
                  ((sub_ff == 2'd3) ? r22_ff + prod : r22_ff - prod);
            r22_in = sum;
            sub_in = sub_ff + 1'b1;
            unique case (sub_ff)
               2'd0: pa = W'(qx_ff);
               2'd1: pa = W'(qy_ff);
               2'd2: pa = W'(qz_ff);
               default: pa = '0;
            endcase
            if (sub_ff == 2'd3) begin
               cmd_in = clamp(acc_ff, lo_ff, hi_ff);
               issue(OP_MUL, GCONST - clamp(acc_ff, lo_ff, hi_ff),
                  W'(signed'({1'b0, mass_ff})));
               st_in = S_NUM;
            end else begin
               issue(OP_MUL, pa, pa);
            end
         end
         S_NUM: if (sdone) begin
            num_in = clamp(fsh, -NLIM, NLIM);
            if (r22_ff <= 0) begin
               thr_in = 32'h7FFFFFFF; flt_in = 1'b1; st_in = S_OUT;
            end else begin
               pb = clamp(fsh, -NLIM, NLIM) <<< 28;
               issue(OP_DIV, pb, r22_ff);
               flt_in = 1'b0;
               st_in = S_DIVT;
            end
         end
         S_DIVT: if (sdone) begin
            thr_in = 32'(clamp(prod, I32MIN, I32MAX));
            st_in = S_OUT;
         end
         // move the step into the output register once it is free
         S_OUT: if (!vld_ff || rsp_tready) begin
            vld_in = 1'b1; out_thr_in = thr_ff; out_flt_in = flt_ff;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0; integ_ff <= '0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in; integ_ff <= integ_in;
      end
      perr_ff <= perr_in; verr_ff <= verr_in; ff_ff <= ff_in; r22_ff <= r22_in;
      acc_ff <= acc_in; cmd_ff <= cmd_in; hi_ff <= hi_in; lo_ff <= lo_in;
      num_ff <= num_in; qw_ff <= qw_in; qx_ff <= qx_in; qy_ff <= qy_in;
      qz_ff <= qz_in; thr_ff <= thr_in; flt_ff <= flt_in; neg_ff <= neg_in;
      sub_ff <= sub_in; out_thr_ff <= out_thr_in; out_flt_ff <= out_flt_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = out_thr_ff;
   assign rsp_tuser = out_flt_ff;

   // checks
   `APTC_ASSERT_IMP(a_fault_sat, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata == 32'h7FFFFFFF)
   `APTC_ASSERT_IMP(a_no_acc_busy, clock, reset, st_ff != S_IDLE, !req_tready)
   `APTC_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
endmodule

FILE: hdl/aptc_serial_unit.sv
// Bit-serial multiplier and divider on magnitudes, one bit per cycle.
// Depends on aptc_pkg.
module aptc_serial_unit #(
   parameter int W = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  aptc_pkg::su_ctl_type ctl,
   input  logic [W-1:0]         opa,
   input  logic [W-1:0]         opb,
   output logic                 done,
   output logic [W-1:0]         res
);
   import aptc_pkg::*;
   localparam int CW = $clog2(W+1);

   logic [W-1:0] acc_ff, acc_in, sh_ff, sh_in, b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, op_ff, op_in, done_ff, done_in;
   logic [W:0] trial;

   always_comb begin
      acc_in = acc_ff; sh_in = sh_ff; b_in = b_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; op_in = op_ff; done_in = 1'b0;
      trial = '0;
      if (ctl.start) begin
         busy_in = 1'b1; cnt_in = CW'(W); op_in = (ctl.op == OP_DIV);
         acc_in = '0; sh_in = opa; b_in = opb;
      end else if (busy_ff) begin
         if (op_ff) begin
            // restoring division: remainder in acc, quotient into sh
            trial = {acc_ff, sh_ff[W-1]} - {1'b0, b_ff};
            if (!trial[W]) acc_in = trial[W-1:0];
            else acc_in = {acc_ff[W-2:0], sh_ff[W-1]};
            sh_in = {sh_ff[W-2:0], ~trial[W]};
         end else begin
            // shift-add multiply, multiplier bits from the top
            acc_in = (acc_ff << 1) + (sh_ff[W-1] ? b_ff : '0);
            sh_in = sh_ff << 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in; sh_ff <= sh_in; b_ff <= b_in; op_ff <= op_in;
   end

   assign done = done_ff;
   assign res = op_ff ? sh_ff : acc_ff;
endmodule
